>>> rtl/grid_flood_fill_top_macros.svh
// Assertion macros used by the flood fill RTL.
`ifndef GRID_FLOOD_FILL_TOP_MACROS_SVH
`define GRID_FLOOD_FILL_TOP_MACROS_SVH

`ifndef SYNTH
`define GFF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flood fill check failed");
`define GFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flood fill check failed");
`else
`define GFF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GFF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/gff_pkg.sv
`default_nettype none

package gff_pkg;

   localparam int MAX_DIM       = 32;
   localparam int COLOR_BITS    = 8;
   localparam int COORD_BITS    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_BITS     = 2 * COORD_BITS;
   localparam int CELL_DEPTH    = 1 << ADDR_BITS;
   localparam int PTR_BITS      = ADDR_BITS + 1;
   localparam int CFG_BITS      = 6;
   localparam int CNT_BITS      = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;
   localparam int MODE_BITS     = 2;
   localparam int POS_BITS      = 5;
   localparam int BYTE_BITS     = 8;
   localparam int STATUS_BITS   = 2;
   localparam int WIDE_BITS     = (COLOR_BITS > BYTE_BITS) ? COLOR_BITS : BYTE_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [COLOR_BITS-1:0]    color_type;
   typedef logic [COORD_BITS-1:0]    coord_type;
   typedef logic [ADDR_BITS-1:0]     addr_type;
   typedef logic [PTR_BITS-1:0]      ptr_type;
   typedef logic [CNT_BITS-1:0]      count_type;
   typedef logic [CFG_BITS-1:0]      cfg_type;
   typedef logic [MODE_BITS-1:0]     mode_type;
   typedef logic [POS_BITS-1:0]      pos_type;
   typedef logic [BYTE_BITS-1:0]     byte_type;
   typedef logic [STATUS_BITS-1:0]   status_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_FILL  = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_SAME    = 2'd1;
   localparam status_type STATUS_OUTSIDE = 2'd2;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   localparam cfg_type RESET_ROWS = 6'd16;
   localparam cfg_type RESET_COLS = 6'd16;

   typedef struct packed {
      count_type rows;
      count_type cols;
   } grid_type;

   typedef enum logic [2:0] {
      FILL_IDLE,
      FILL_SEED,
      FILL_QREAD,
      FILL_NBREAD,
      FILL_NBCHECK,
      FILL_DONE
   } fill_state_type;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } dir_type;

   function automatic color_type color_of(byte_type b);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(b);
      return w[COLOR_BITS-1:0];
   endfunction

   function automatic byte_type byte_of(color_type c);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(c);
      return w[BYTE_BITS-1:0];
   endfunction

   function automatic addr_type cell_addr(coord_type r, coord_type c);
      return {r, c};
   endfunction

endpackage

`default_nettype wire

>>> rtl/gff_if.sv
`default_nettype none

interface gff_req_if import gff_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type mode;
   pos_type  row;
   pos_type  col;
   byte_type color;

   modport source (output valid, output mode, output row, output col, output color,
                   input ready);
   modport sink (input valid, input mode, input row, input col, input color,
                 output ready);
endinterface

interface gff_rsp_if import gff_pkg::*; ();
   logic       valid;
   logic       ready;
   byte_type   read_color;
   status_type status;

   modport source (output valid, output read_color, output status, input ready);
   modport sink (input valid, input read_color, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/gff_ram.sv
`default_nettype none

module gff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/gff_csr.sv
`default_nettype none

module gff_csr import gff_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  csr_data_type             pwdata,
   output csr_data_type             prdata,
   output logic                     pready,
   output grid_type                 grid
);

   cfg_type rows_ff;
   cfg_type rows_in;
   cfg_type cols_ff;
   cfg_type cols_in;
   logic    write_en;
   logic    reg_index;

   function automatic count_type saturate(cfg_type v);
      if (count_type'(v) > count_type'(MAX_DIM)) begin
         return count_type'(MAX_DIM);
      end
      return count_type'(v);
   endfunction

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite && pready;
   assign reg_index = paddr[CSR_ADDR_BITS-1];

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (write_en) begin
         case (reg_index)
            REG_ROW_COUNT: rows_in = pwdata[CFG_BITS-1:0];
            REG_COL_COUNT: cols_in = pwdata[CFG_BITS-1:0];
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RESET_ROWS;
         cols_ff <= RESET_COLS;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROW_COUNT: prdata = CSR_DATA_BITS'(rows_ff);
         REG_COL_COUNT: prdata = CSR_DATA_BITS'(cols_ff);
         default:       prdata = '0;
      endcase
   end

   assign grid.rows = saturate(rows_ff);
   assign grid.cols = saturate(cols_ff);

endmodule

`default_nettype wire

>>> rtl/gff_fill.sv
`default_nettype none
`include "grid_flood_fill_top_macros.svh"

module gff_fill import gff_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  grid_type grid,
   gff_req_if.sink   req,
   gff_rsp_if.source rsp
);

   fill_state_type state_ff;
   fill_state_type state_in;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_read_ff;
   logic       s1_read_in;
   status_type s1_status_ff;
   status_type s1_status_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   byte_type   rsp_color_ff;
   byte_type   rsp_color_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;

   status_type fill_status_ff;
   status_type fill_status_in;
   addr_type   seed_ff;
   addr_type   seed_in;
   color_type  fill_color_ff;
   color_type  fill_color_in;
   color_type  old_ff;
   color_type  old_in;
   ptr_type    head_ff;
   ptr_type    head_in;
   ptr_type    tail_ff;
   ptr_type    tail_in;
   dir_type    dir_ff;
   dir_type    dir_in;

   logic      pix_we;
   addr_type  pix_waddr;
   color_type pix_wdata;
   logic      pix_re;
   addr_type  pix_raddr;
   color_type pix_rdata;
   logic      q_we;
   addr_type  q_waddr;
   addr_type  q_wdata;
   logic      q_re;
   addr_type  q_raddr;
   addr_type  q_rdata;

   logic      slot_free;
   logic      s1_move;
   logic      accept;
   logic      in_grid;
   logic      fill_start;
   addr_type  req_addr;
   coord_type cur_r;
   coord_type cur_c;
   coord_type nb_r;
   coord_type nb_c;
   logic      nb_ok;
   addr_type  nb_addr;
   logic      seed_same;
   logic      nb_match;
   logic      last_dir;

   gff_ram #(.WIDTH(COLOR_BITS), .DEPTH(CELL_DEPTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (pix_waddr),
      .wr_data (pix_wdata),
      .rd_en   (pix_re),
      .rd_addr (pix_raddr),
      .rd_data (pix_rdata)
   );

   gff_ram #(.WIDTH(ADDR_BITS), .DEPTH(CELL_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   assign slot_free  = !rsp_valid_ff || rsp.ready;
   assign s1_move    = s1_valid_ff && slot_free;
   assign req.ready  = (state_ff == FILL_IDLE) && (!s1_valid_ff || slot_free);
   assign accept     = req.valid && req.ready;
   assign in_grid    = (count_type'(req.row) < grid.rows) && (count_type'(req.col) < grid.cols);
   assign fill_start = accept && (req.mode == MODE_FILL) && in_grid;
   assign req_addr   = cell_addr(coord_type'(req.row), coord_type'(req.col));

   assign cur_r     = q_rdata[ADDR_BITS-1:COORD_BITS];
   assign cur_c     = q_rdata[COORD_BITS-1:0];
   assign seed_same = (pix_rdata == fill_color_ff);
   assign nb_match  = (pix_rdata == old_ff);
   assign last_dir  = (dir_ff == DIR_RIGHT);

   always_comb begin
      nb_ok = 1'b0;
      nb_r  = cur_r;
      nb_c  = cur_c;
      case (dir_ff)
         DIR_UP: begin
            nb_ok = (cur_r != '0);
            nb_r  = cur_r - coord_type'(1);
         end
         DIR_DOWN: begin
            nb_ok = (count_type'(cur_r) + count_type'(1)) < grid.rows;
            nb_r  = cur_r + coord_type'(1);
         end
         DIR_LEFT: begin
            nb_ok = (cur_c != '0);
            nb_c  = cur_c - coord_type'(1);
         end
         DIR_RIGHT: begin
            nb_ok = (count_type'(cur_c) + count_type'(1)) < grid.cols;
            nb_c  = cur_c + coord_type'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   assign nb_addr = cell_addr(nb_r, nb_c);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FILL_IDLE: begin
            if (fill_start) begin
               state_in = FILL_SEED;
            end
         end
         FILL_SEED: begin
            state_in = seed_same ? FILL_DONE : FILL_QREAD;
         end
         FILL_QREAD: begin
            state_in = (head_ff == tail_ff) ? FILL_DONE : FILL_NBREAD;
         end
         FILL_NBREAD: begin
            if (nb_ok) begin
               state_in = FILL_NBCHECK;
            end else if (last_dir) begin
               state_in = FILL_QREAD;
            end
         end
         FILL_NBCHECK: begin
            state_in = last_dir ? FILL_QREAD : FILL_NBREAD;
         end
         FILL_DONE: begin
            if (slot_free) begin
               state_in = FILL_IDLE;
            end
         end
         default: begin
            state_in = FILL_IDLE;
         end
      endcase
   end

   always_comb begin
      pix_we         = 1'b0;
      pix_waddr      = nb_addr;
      pix_wdata      = fill_color_ff;
      pix_re         = 1'b0;
      pix_raddr      = nb_addr;
      q_we           = 1'b0;
      q_waddr        = tail_ff[ADDR_BITS-1:0];
      q_wdata        = nb_addr;
      q_re           = 1'b0;
      q_raddr        = head_ff[ADDR_BITS-1:0];
      head_in        = head_ff;
      tail_in        = tail_ff;
      dir_in         = dir_ff;
      seed_in        = seed_ff;
      fill_color_in  = fill_color_ff;
      old_in         = old_ff;
      fill_status_in = fill_status_ff;
      case (state_ff)
         FILL_IDLE: begin
            pix_waddr     = req_addr;
            pix_wdata     = color_of(req.color);
            pix_raddr     = req_addr;
            pix_we        = accept && (req.mode == MODE_WRITE) && in_grid;
            pix_re        = accept && in_grid &&
                            ((req.mode == MODE_READ) || (req.mode == MODE_FILL));
            seed_in       = req_addr;
            fill_color_in = color_of(req.color);
         end
         FILL_SEED: begin
            old_in         = pix_rdata;
            fill_status_in = seed_same ? STATUS_SAME : STATUS_OK;
            if (!seed_same) begin
               pix_we    = 1'b1;
               pix_waddr = seed_ff;
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata   = seed_ff;
               head_in   = '0;
               tail_in   = ptr_type'(1);
            end
         end
         FILL_QREAD: begin
            dir_in = DIR_UP;
            if (head_ff != tail_ff) begin
               q_re    = 1'b1;
               head_in = head_ff + ptr_type'(1);
            end
         end
         FILL_NBREAD: begin
            if (nb_ok) begin
               pix_re = 1'b1;
            end else if (!last_dir) begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end
         FILL_NBCHECK: begin
            if (nb_match) begin
               pix_we  = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + ptr_type'(1);
            end
            if (!last_dir) begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end
         FILL_DONE: begin
            pix_we = 1'b0;
         end
         default: begin
            pix_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff && !slot_free;
      s1_read_in   = s1_read_ff;
      s1_status_in = s1_status_ff;
      if (accept && !fill_start) begin
         s1_valid_in  = 1'b1;
         s1_read_in   = (req.mode == MODE_READ) && in_grid;
         s1_status_in = STATUS_OK;
         if (!in_grid && ((req.mode == MODE_WRITE) || (req.mode == MODE_FILL) ||
                          (req.mode == MODE_READ))) begin
            s1_status_in = STATUS_OUTSIDE;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_color_in  = rsp_color_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_color_in  = s1_read_ff ? byte_of(pix_rdata) : '0;
         rsp_status_in = s1_status_ff;
      end else if ((state_ff == FILL_DONE) && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_color_in  = '0;
         rsp_status_in = fill_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FILL_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         old_ff       <= '0;
         dir_ff       <= DIR_UP;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         old_ff       <= old_in;
         dir_ff       <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff     <= s1_read_in;
      s1_status_ff   <= s1_status_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_status_ff  <= rsp_status_in;
      fill_status_ff <= fill_status_in;
      seed_ff        <= seed_in;
      fill_color_ff  <= fill_color_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_color = rsp_color_ff;
   assign rsp.status     = rsp_status_ff;

   `GFF_ASSERT_IMPLY(a_head_le_tail, clock, reset, 1'b1, head_ff <= tail_ff)
   `GFF_ASSERT_IMPLY(a_tail_bound, clock, reset, 1'b1, tail_ff <= ptr_type'(CELL_DEPTH))
   `GFF_ASSERT_IMPLY(a_s1_empty_in_fill, clock, reset, state_ff != FILL_IDLE, !s1_valid_ff)
   `GFF_ASSERT_NEXT(a_fill_enters_seed, clock, reset, fill_start, state_ff == FILL_SEED)
   `GFF_ASSERT_IMPLY(a_pixel_port_excl, clock, reset, pix_we, !pix_re)

endmodule

`default_nettype wire

>>> rtl/grid_flood_fill_top.sv
// Pixel write, pixel read and rejected transactions pass the s1 and output registers, one
// transaction per cycle while the output is not held off. Fill: a seed check, then per cell
// recoloured a queue read and then a pixel read and a check for each neighbour inside
// the grid; input is held off until the result is loaded. An unchanged seed goes from
// the seed check straight to the result. Reset clears control, queue pointers and the seed
// colour and sets both counts to 16; the pixel memory is not cleared, so no clearing pass.
`default_nettype none

module grid_flood_fill_top import gff_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   gff_req_if.sink                  req_bus,
   gff_rsp_if.source                rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  csr_data_type             pwdata,
   output csr_data_type             prdata,
   output logic                     pready
);

   grid_type grid;

   gff_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .grid    (grid)
   );

   gff_fill u_fill (
      .clock (clock),
      .reset (reset),
      .grid  (grid),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> tb/tb_grid_flood_fill_top.sv
`timescale 1ns / 100ps

module tb_grid_flood_fill_top;
   import gff_pkg::*;

   localparam mode_type MODE_UNUSED = 2'd3;

   typedef struct packed {
      byte_type   read_color;
      status_type status;
   } reply_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   csr_data_type             pwdata;
   csr_data_type             prdata;
   logic                     pready;

   gff_req_if req_bus ();
   gff_rsp_if rsp_bus ();

   grid_flood_fill_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   color_type pixel_model [CELL_DEPTH];
   bit        pixel_known [CELL_DEPTH];
   cfg_type   rows_reg;
   cfg_type   cols_reg;
   reply_type pending_replies [$];
   int        fail_count = 0;
   bit        idle_on = 1'b0;
   int        rsp_hold = 0;
   int        sent_total = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("Verification failed");
      $finish;
   end

   function automatic int grid_rows();
      return (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
   endfunction

   function automatic int grid_cols();
      return (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(12, 40);
   endfunction

   function automatic byte_type palette_color();
      if ($urandom_range(0, 4) == 0) begin
         return byte_type'($urandom_range(0, 255));
      end
      return byte_type'($urandom_range(0, 2));
   endfunction

   // Breadth-first recolouring of the 4-connected region holding the old colour.
   function automatic void flood_region(int row, int col, color_type old_color,
                                        color_type new_color);
      int     work [$];
      int     addr;
      int     r;
      int     c;
      int     nr;
      int     nc;
      dir_type dir;
      addr = row * MAX_DIM + col;
      pixel_model[addr] = new_color;
      work.push_back(addr);
      while (work.size() != 0) begin
         addr = work.pop_front();
         r = addr / MAX_DIM;
         c = addr % MAX_DIM;
         for (int d = 0; d < 4; d++) begin
            dir = dir_type'(d);
            nr = r;
            nc = c;
            case (dir)
               DIR_UP: begin
                  nr = r - 1;
               end
               DIR_DOWN: begin
                  nr = r + 1;
               end
               DIR_LEFT: begin
                  nc = c - 1;
               end
               default: begin
                  nc = c + 1;
               end
            endcase
            if (nr >= 0 && nr < grid_rows() && nc >= 0 && nc < grid_cols()) begin
               if (pixel_model[nr * MAX_DIM + nc] == old_color) begin
                  pixel_model[nr * MAX_DIM + nc] = new_color;
                  work.push_back(nr * MAX_DIM + nc);
               end
            end
         end
      end
   endfunction

   function automatic reply_type predict_grid_op(mode_type mode, pos_type row, pos_type col,
                                                 byte_type color);
      reply_type reply;
      int        addr;
      color_type old_color;
      reply = '0;
      if (mode != MODE_UNUSED) begin
         if (int'(row) >= grid_rows() || int'(col) >= grid_cols()) begin
            reply.status = STATUS_OUTSIDE;
         end else begin
            addr = int'(row) * MAX_DIM + int'(col);
            if (mode == MODE_WRITE) begin
               pixel_model[addr] = color_type'(color);
               pixel_known[addr] = 1'b1;
            end else if (mode == MODE_READ) begin
               reply.read_color = byte_type'(pixel_model[addr]);
            end else begin
               old_color = pixel_model[addr];
               if (old_color == color_type'(color)) begin
                  reply.status = STATUS_SAME;
               end else begin
                  flood_region(row, col, old_color, color_type'(color));
               end
            end
         end
      end
      return reply;
   endfunction

   task automatic send_op(mode_type mode, int row, int col, byte_type color);
      int gap;
      gap = idle_on ? idle_length() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.row   <= pos_type'(row);
      req_bus.col   <= pos_type'(col);
      req_bus.color <= color;
      do @(posedge clock); while (!req_bus.ready);
      pending_replies.push_back(predict_grid_op(mode, pos_type'(row), pos_type'(col), color));
      sent_total++;
   endtask

   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic write_count_reg(logic reg_index, cfg_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= {26'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_index == REG_ROW_COUNT) begin
         rows_reg = value;
      end else begin
         cols_reg = value;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(cfg_type rows, cfg_type cols);
      wait_for_replies();
      repeat (4) @(posedge clock);
      write_count_reg(REG_ROW_COUNT, rows);
      write_count_reg(REG_COL_COUNT, cols);
   endtask

   // Every cell of the grid in use is written before any read or fill touches it.
   task automatic populate_grid(output int sent);
      sent = 0;
      for (int r = 0; r < grid_rows(); r++) begin
         for (int c = 0; c < grid_cols(); c++) begin
            if (!pixel_known[r * MAX_DIM + c]) begin
               send_op(MODE_WRITE, r, c, palette_color());
               sent++;
            end
         end
      end
   endtask

   task automatic test_directed_ops();
      int sent;
      set_grid(6'd2, 6'd2);
      send_op(MODE_WRITE, 0, 0, 8'h00);
      send_op(MODE_WRITE, 0, 1, 8'hFF);
      send_op(MODE_WRITE, 1, 0, 8'h00);
      send_op(MODE_WRITE, 1, 1, 8'h00);
      send_op(MODE_READ, 0, 1, 8'h00);
      send_op(MODE_READ, 1, 1, 8'hFF);
      send_op(MODE_FILL, 0, 0, 8'h00);
      send_op(MODE_FILL, 0, 0, 8'hA5);
      send_op(MODE_READ, 1, 1, 8'h00);
      send_op(MODE_READ, 0, 1, 8'h00);
      send_op(MODE_WRITE, 31, 31, 8'hFF);
      send_op(MODE_READ, 2, 0, 8'h00);
      send_op(MODE_FILL, 0, 2, 8'h5A);
      send_op(MODE_UNUSED, 31, 31, 8'hFF);
      send_op(MODE_UNUSED, 0, 0, 8'h00);
      send_op(MODE_FILL, 1, 1, 8'hA5);
      send_op(MODE_FILL, 0, 1, 8'hA5);
      send_op(MODE_READ, 0, 0, 8'h00);
      set_grid(6'd1, 6'd1);
      populate_grid(sent);
      send_op(MODE_FILL, 0, 0, 8'h3C);
      send_op(MODE_READ, 0, 0, 8'h00);
      send_op(MODE_READ, 0, 1, 8'h00);
   endtask

   task automatic test_grid_extremes();
      int sent;
      set_grid(6'd0, 6'd16);
      send_op(MODE_WRITE, 0, 0, 8'h11);
      send_op(MODE_READ, 0, 0, 8'h00);
      send_op(MODE_FILL, 0, 0, 8'h22);
      set_grid(6'd16, 6'd0);
      send_op(MODE_READ, 0, 0, 8'h00);
      set_grid(6'd1, 6'd32);
      populate_grid(sent);
      send_op(MODE_FILL, 0, 31, 8'h80);
      send_op(MODE_READ, 0, 31, 8'h00);
      send_op(MODE_READ, 1, 0, 8'h00);
      set_grid(6'd32, 6'd1);
      populate_grid(sent);
      send_op(MODE_FILL, 31, 0, 8'h40);
      send_op(MODE_READ, 31, 0, 8'h00);
      send_op(MODE_WRITE, 0, 1, 8'h40);
      idle_on = 1'b1;
      set_grid(6'd63, 6'd63);
      send_op(MODE_WRITE, 31, 31, 8'hC0);
      send_op(MODE_WRITE, 30, 31, 8'h11);
      send_op(MODE_WRITE, 31, 30, 8'h11);
      send_op(MODE_FILL, 31, 31, 8'hC3);
      send_op(MODE_READ, 31, 31, 8'h00);
      send_op(MODE_FILL, 31, 31, 8'hC3);
      send_op(MODE_WRITE, 16, 16, 8'h7E);
      send_op(MODE_READ, 16, 16, 8'h00);
      set_grid(6'd32, 6'd33);
      send_op(MODE_READ, 0, 0, 8'h00);
      send_op(MODE_FILL, 31, 31, 8'h02);
      send_op(MODE_READ, 31, 31, 8'h00);
      send_op(MODE_READ, 31, 0, 8'h00);
   endtask

   function automatic cfg_type random_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
         return cfg_type'($urandom_range(1, 6));
      end else if (roll < 84) begin
         return cfg_type'($urandom_range(7, 16));
      end else if (roll < 89) begin
         return cfg_type'($urandom_range(17, 32));
      end else if (roll < 93) begin
         return cfg_type'(0);
      end else if (roll < 96) begin
         return cfg_type'($urandom_range(33, 63));
      end
      return ($urandom_range(0, 1) != 0) ? cfg_type'(1) : cfg_type'(32);
   endfunction

   function automatic int unknown_cells(cfg_type rows, cfg_type cols);
      int total;
      int nr;
      int nc;
      total = 0;
      nr = (rows > MAX_DIM) ? MAX_DIM : int'(rows);
      nc = (cols > MAX_DIM) ? MAX_DIM : int'(cols);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            if (!pixel_known[r * MAX_DIM + c]) begin
               total++;
            end
         end
      end
      return total;
   endfunction

   task automatic test_random_traffic();
      int      done;
      int      sent;
      int      phase_ops;
      int      rows;
      int      cols;
      int      roll;
      int      r;
      int      c;
      cfg_type want_rows;
      cfg_type want_cols;
      done = sent_total;
      while (done < 650) begin
         idle_on = ($urandom_range(0, 3) != 0);
         do begin
            want_rows = random_count();
            want_cols = random_count();
         end while (unknown_cells(want_rows, want_cols) > 96);
         set_grid(want_rows, want_cols);
         rows = grid_rows();
         cols = grid_cols();
         populate_grid(sent);
         done += sent;
         phase_ops = (rows * cols > 256) ? 15 : $urandom_range(20, 50);
         for (int i = 0; i < phase_ops; i++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) begin
               wait_for_replies();
            end
            if (roll < 4) begin
               send_op(MODE_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                       byte_type'($urandom_range(0, 255)));
            end else if ((rows == 0 || cols == 0 || roll < 12) &&
                         (rows < MAX_DIM || cols < MAX_DIM)) begin
               r = $urandom_range(0, 31);
               c = $urandom_range(0, 31);
               if (rows < MAX_DIM && (cols == MAX_DIM || $urandom_range(0, 1) != 0)) begin
                  r = $urandom_range(rows, 31);
               end else begin
                  c = $urandom_range(cols, 31);
               end
               send_op(mode_type'($urandom_range(0, 2)), r, c,
                       byte_type'($urandom_range(0, 255)));
               done++;
            end else begin
               r = $urandom_range(0, rows - 1);
               c = $urandom_range(0, cols - 1);
               if (roll < 42) begin
                  send_op(MODE_WRITE, r, c, palette_color());
               end else if (roll < 72) begin
                  send_op(MODE_FILL, r, c, palette_color());
               end else begin
                  send_op(MODE_READ, r, c, byte_type'($urandom_range(0, 255)));
               end
               done++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= idle_length();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_reply
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected transaction: read_color %0h status %0d",
                   rsp_bus.read_color, rsp_bus.status);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.read_color !== want.read_color) begin
               $error("read_color expected %0h actual %0h", want.read_color,
                      rsp_bus.read_color);
               fail_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_bus.status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode  <= MODE_WRITE;
      req_bus.row   <= '0;
      req_bus.col   <= '0;
      req_bus.color <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      rows_reg = RESET_ROWS;
      cols_reg = RESET_COLS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_grid_extremes();
      test_random_traffic();
      wait_for_replies();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gff_pkg.sv
rtl/gff_if.sv
rtl/gff_ram.sv
rtl/gff_csr.sv
rtl/gff_fill.sv
rtl/grid_flood_fill_top.sv
tb/tb_grid_flood_fill_top.sv
